@@ rtl/core/crc_byte_word_engine_assert.svh @@
// Assertion macros for the CRC engine checker.
// Needs nothing else; included by the checker file.
`ifndef CRC_BYTE_WORD_ENGINE_ASSERT_SVH
`define CRC_BYTE_WORD_ENGINE_ASSERT_SVH

// Concurrent check, disabled while reset is high.
`define CRCW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("crc_byte_word_engine check failed");

// Concurrent check that also runs during reset.
`define CRCW_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("crc_byte_word_engine reset check failed");

`endif

@@ rtl/core/crcw_pkg.sv @@
// Shared types, constants and bit helpers for the CRC byte/word engine.
// No dependencies; imported by the table, lane, merge and top-level modules.
package crcw_pkg;

   localparam int LANES       = 8;   // bytes per transaction, one lane each
   localparam int CRC_W       = 64;
   localparam int ROWS        = 64;  // residues x^(W+i) mod P, i = 0..63
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLYNOMIAL     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_IS_64    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFLECTED_MODE = 2'd2;

   localparam logic [CRC_W-1:0] POLY_RESET = 64'h0000_0000_1EDC_6F41;

   typedef struct packed {
      logic [CRC_W-1:0] polynomial;
      logic             width_is_64;
      logic             reflected_mode;
   } cfg_type;

   typedef logic [ROWS-1:0][CRC_W-1:0]  row_array_type;
   typedef logic [7:0][CRC_W-1:0]       lane_rows_type;
   typedef logic [LANES-1:0][CRC_W-1:0] lane_sum_type;

   function automatic logic [CRC_W-1:0] width_mask(input logic w64);
      return w64 ? {CRC_W{1'b1}} : {{(CRC_W/2){1'b0}}, {(CRC_W/2){1'b1}}};
   endfunction

   // Bit reverse within the active CRC width.
   function automatic logic [CRC_W-1:0] reverse_crc(input logic [CRC_W-1:0] v,
                                                    input logic w64);
      logic [CRC_W-1:0]   r64;
      logic [CRC_W/2-1:0] r32;
      for (int i = 0; i < CRC_W; i++) r64[i] = v[CRC_W-1-i];
      for (int i = 0; i < CRC_W/2; i++) r32[i] = v[CRC_W/2-1-i];
      return w64 ? r64 : {{(CRC_W/2){1'b0}}, r32};
   endfunction

   function automatic logic [7:0] reverse_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
   endfunction

endpackage

@@ rtl/core/crcw_table.sv @@
// Residue table: row i holds x^(W+i) mod P for the configured polynomial.
// Rebuilt one row per cycle after reset and after every register write. Uses crcw_pkg.
module crcw_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_write,
   input  crcw_pkg::cfg_type      cfg,
   output crcw_pkg::row_array_type rows,
   output logic                   ready
);
   import crcw_pkg::*;

   logic                  start_ff, start_in;
   logic                  busy_ff, busy_in;
   logic [5:0]            idx_ff, idx_in;
   logic [CRC_W-1:0]      cur_ff, cur_in;
   logic [CRC_W-1:0]      mask, poly_m, next_row;
   logic                  top_bit;
   row_array_type         rows_ff;

   assign mask     = width_mask(cfg.width_is_64);
   assign poly_m   = cfg.polynomial & mask;
   assign top_bit  = cfg.width_is_64 ? cur_ff[CRC_W-1] : cur_ff[CRC_W/2-1];
   assign next_row = ((cur_ff << 1) & mask) ^ (top_bit ? poly_m : '0);

   always_comb begin
      start_in = start_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cur_in   = cur_ff;
      if (cfg_write) begin
         start_in = 1'b1;
         busy_in  = 1'b0;
      end else if (start_ff) begin
         start_in = 1'b0;
         busy_in  = 1'b1;
         idx_in   = '0;
         cur_in   = poly_m;   // x^W mod P
      end else if (busy_ff) begin
         cur_in = next_row;
         idx_in = idx_ff + 6'd1;
         if (idx_ff == 6'(ROWS-1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         start_ff <= start_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
      end
      cur_ff <= cur_in;
      if (busy_ff && !cfg_write) begin
         rows_ff[idx_ff] <= cur_ff;
      end
   end

   assign rows  = rows_ff;
   assign ready = !start_ff && !busy_ff;

endmodule

@@ rtl/core/crcw_lane.sv @@
// One byte lane: folds its byte into the residue rows of its fixed position
// and registers the partial CRC. Uses crcw_pkg.
module crcw_lane (
   input  logic                    clock,
   input  logic                    enable,
   input  logic                    reflected_mode,
   input  logic [7:0]              data_byte,
   input  crcw_pkg::lane_rows_type lane_rows,
   output logic [crcw_pkg::CRC_W-1:0] partial
);
   import crcw_pkg::*;

   logic [7:0]       bits;
   logic [CRC_W-1:0] partial_in, partial_ff;

   // reflected bytes enter in mirrored order
   assign bits = reflected_mode ? reverse_byte(data_byte) : data_byte;

   always_comb begin
      partial_in = '0;
      for (int j = 0; j < 8; j++) begin
         if (bits[j]) partial_in = partial_in ^ lane_rows[j];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         partial_ff <= partial_in;
      end
   end

   assign partial = partial_ff;

endmodule

@@ rtl/core/crcw_merge.sv @@
// Merge stage: XORs the lane partials and folds the start value through
// the item's byte count using the residue rows. Uses crcw_pkg.
module crcw_merge (
   input  logic                        width_is_64,
   input  logic [crcw_pkg::CRC_W-1:0]  start_value,
   input  logic [3:0]                  byte_count,
   input  crcw_pkg::lane_sum_type      lane_partials,
   input  crcw_pkg::row_array_type     rows,
   output logic [crcw_pkg::CRC_W-1:0]  crc_out
);
   import crcw_pkg::*;

   logic [2*CRC_W-1:0] shifted;
   logic [CRC_W-1:0]   low_part, high_part, fold, data_sum;

   // start * x^(8n): bits at and above W reduce through the residue rows
   assign shifted   = {{CRC_W{1'b0}}, start_value} << {byte_count, 3'b000};
   assign low_part  = shifted[CRC_W-1:0] & width_mask(width_is_64);
   assign high_part = width_is_64 ? shifted[2*CRC_W-1:CRC_W]
                                  : shifted[CRC_W+CRC_W/2-1:CRC_W/2];

   always_comb begin
      fold = '0;
      for (int i = 0; i < ROWS; i++) begin
         if (high_part[i]) fold = fold ^ rows[i];
      end
      data_sum = '0;
      for (int k = 0; k < LANES; k++) begin
         data_sum = data_sum ^ lane_partials[k];
      end
   end

   assign crc_out = low_part ^ fold ^ data_sum;

endmodule

@@ rtl/core/crc_byte_word_engine.sv @@
// Running CRC engine, 32 or 64 bit, reflected or normal, up to 8 bytes per transaction.
// Top level; uses crcw_pkg, crcw_table, crcw_lane and crcw_merge.
//
// Channels: req_* carries one transaction of up to eight data bytes (byte 0 in
// bits 7:0 goes first), a byte count, a restart flag with seed and an end flag.
// rsp_* returns one CRC value per transaction, with the end flag echoed.
// csr_* writes polynomial (0), width_is_64 (1) and reflected_mode (2); always ready.
// Throughput: one transaction per cycle while the table is ready and rsp_ready is high.
// A request is registered in the lane stage, its result in the output register. Eight
// byte lanes fold their bytes in the first stage; the merge stage adds the running
// state through a residue table, so the state loop closes within the merge stage.
// Reset clears the running CRC and the registers to their defaults, then the
// residue table is rebuilt with req_ready low. Every register write rebuilds
// the table the same way, with req_ready low.
// When rsp_ready is low one result waits in the output register and one more
// transaction can be accepted into the lane stage; then req_ready drops.
module crc_byte_word_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   input  logic [63:0]                         req_seed,
   input  logic [63:0]                         req_data_word,
   input  logic [3:0]                          req_byte_count,
   input  logic                                req_end_of_message,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [63:0]                         rsp_crc_value,
   output logic                                rsp_is_final,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crcw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_write_data
);
   import crcw_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   row_array_type    rows;
   logic             table_ready;

   logic             req_fire, s1_fire;
   logic [3:0]       count_sat, gap;
   logic [CRC_W-1:0] padded;
   lane_rows_type [LANES-1:0] lane_rows;
   lane_sum_type     lane_partials;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_restart_ff;
   logic [CRC_W-1:0] s1_seed_ff;
   logic [3:0]       s1_count_ff;
   logic             s1_final_ff;

   logic [CRC_W-1:0] crc_state_ff;
   logic [CRC_W-1:0] start_ext, start_int, crc_int, crc_ext;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff;
   logic             rsp_final_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_POLYNOMIAL:     cfg_in.polynomial     = csr_write_data;
            CSR_WIDTH_IS_64:    cfg_in.width_is_64    = csr_write_data[0];
            CSR_REFLECTED_MODE: cfg_in.reflected_mode = csr_write_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   crcw_table u_table (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (csr_write),
      .cfg       (cfg_ff),
      .rows      (rows),
      .ready     (table_ready)
   );

   // handshake
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = table_ready && (!s1_valid_ff || s1_fire);
   assign req_fire  = req_valid && req_ready;

   // right-align the valid bytes to the last lane; leading zero bytes
   // leave a zero-state CRC unchanged
   assign count_sat = (req_byte_count > 4'(LANES)) ? 4'(LANES) : req_byte_count;
   assign gap       = 4'(LANES) - count_sat;
   assign padded    = req_data_word << {gap, 3'b000};

   always_comb begin
      for (int p = 0; p < LANES; p++) begin
         for (int j = 0; j < 8; j++) begin
            lane_rows[p][j] = rows[8*(LANES-1-p)+j];
         end
      end
   end

   for (genvar p = 0; p < LANES; p++) begin : g_lane
      crcw_lane u_lane (
         .clock          (clock),
         .enable         (req_fire),
         .reflected_mode (cfg_ff.reflected_mode),
         .data_byte      (padded[8*p +: 8]),
         .lane_rows      (lane_rows[p]),
         .partial        (lane_partials[p])
      );
   end

   // merge stage: start value in normal bit order
   assign start_ext = (s1_restart_ff ? s1_seed_ff : crc_state_ff)
                      & width_mask(cfg_ff.width_is_64);
   assign start_int = cfg_ff.reflected_mode ? reverse_crc(start_ext, cfg_ff.width_is_64)
                                            : start_ext;

   crcw_merge u_merge (
      .width_is_64   (cfg_ff.width_is_64),
      .start_value   (start_int),
      .byte_count    (s1_count_ff),
      .lane_partials (lane_partials),
      .rows          (rows),
      .crc_out       (crc_int)
   );

   assign crc_ext = cfg_ff.reflected_mode ? reverse_crc(crc_int, cfg_ff.width_is_64)
                                          : crc_int;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial     <= POLY_RESET;
         cfg_ff.width_is_64    <= 1'b0;
         cfg_ff.reflected_mode <= 1'b1;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         crc_state_ff          <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            crc_state_ff <= crc_ext;
         end
      end
      if (req_fire) begin
         s1_restart_ff <= req_restart;
         s1_seed_ff    <= req_seed;
         s1_count_ff   <= count_sat;
         s1_final_ff   <= req_end_of_message;
      end
      if (s1_fire) begin
         rsp_crc_ff   <= crc_ext;
         rsp_final_ff <= s1_final_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;
   assign rsp_is_final  = rsp_final_ff;

endmodule

@@ rtl/core/crcw_checker.sv @@
// Port-level checker for the CRC engine, attached to the top level by bind.
// Uses the macros of crc_byte_word_engine_assert.svh.
`include "crc_byte_word_engine_assert.svh"

module crcw_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_valid,
   input logic csr_ready
);

   // a pending result is not withdrawn
   `CRCW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // table rebuild follows every register write
   `CRCW_ASSERT(a_csr_blocks_req, clock, reset, csr_valid && csr_ready |=> !req_ready)

   // nothing accepted or presented right after reset
   `CRCW_ASSERT_NR(a_reset_quiet, clock, reset |=> !req_ready && !rsp_valid)

endmodule

bind crc_byte_word_engine crcw_checker u_checker (.*);
